[rtl/core/lstp_pkg.sv]
package lstp_pkg;

  // Default for the MAX_BEAMS parameter of the top level.
  localparam int MAX_BEAMS_DEF = 4096;

  // Pipeline depths of the angle reduction and of the CORDIC.
  localparam int RED_STEPS    = 13;
  localparam int CORDIC_STEPS = 28;

  // Angles in Q.28 radians, CORDIC start value in Q.30.
  localparam logic [44:0]        ANG_TWO_PI  = 45'd1686629713;
  localparam logic signed [31:0] ANG_PI      = 32'sd843314857;
  localparam logic signed [31:0] ANG_HALF_PI = 32'sd421657428;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_RANGE_MIN   = 3'd0,
    REG_RANGE_MAX   = 3'd1,
    REG_ANGLE_START = 3'd2,
    REG_ANGLE_STEP  = 3'd3,
    REG_ROT_ROW_X   = 3'd4,
    REG_ROT_ROW_Y   = 3'd5,
    REG_OFFSET_X    = 3'd6,
    REG_OFFSET_Y    = 3'd7
  } cfg_reg_t;

  // Arctangent of 2^-i in Q.28 radians.
  function automatic logic signed [31:0] atan_entry(input int i);
    logic signed [31:0] val;
    unique case (i)
      0:  val = 32'sd210828714;
      1:  val = 32'sd124459457;
      2:  val = 32'sd65760959;
      3:  val = 32'sd33381290;
      4:  val = 32'sd16755422;
      5:  val = 32'sd8385879;
      6:  val = 32'sd4193963;
      7:  val = 32'sd2097109;
      8:  val = 32'sd1048571;
      9:  val = 32'sd524287;
      10: val = 32'sd262144;
      11: val = 32'sd131072;
      12: val = 32'sd65536;
      13: val = 32'sd32768;
      14: val = 32'sd16384;
      15: val = 32'sd8192;
      16: val = 32'sd4096;
      17: val = 32'sd2048;
      18: val = 32'sd1024;
      19: val = 32'sd512;
      20: val = 32'sd256;
      21: val = 32'sd128;
      22: val = 32'sd64;
      23: val = 32'sd32;
      24: val = 32'sd16;
      25: val = 32'sd8;
      26: val = 32'sd4;
      27: val = 32'sd2;
      default: val = 32'sd0;
    endcase
    return val;
  endfunction

endpackage

[rtl/core/laser_scan_to_points.sv]
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   beam_index, beam_range
// out       output     out_valid / out_ready point_x, point_y
// cfg       input      cfg_we                cfg_index, cfg_data
//
// The pipeline has 52 register stages; the first is loaded at the edge that
// accepts a beam, and its point then passes through every stage to the output register.
// One beam can enter in every cycle while the output does not stall; most of the depth
// comes from the 13 angle reduction steps and the 28 CORDIC iterations, one per stage.
// Reset is synchronous, clears the valid bits and loads the configuration register defaults.
// A stall on the output freezes the whole pipeline, so nothing is lost or repeated.
module laser_scan_to_points #(
  parameter int MAX_BEAMS = lstp_pkg::MAX_BEAMS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [11:0]        beam_index,
  input  logic [23:0]        beam_range,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [35:0]        cfg_data
);

  localparam int RN = lstp_pkg::RED_STEPS;
  localparam int CN = lstp_pkg::CORDIC_STEPS;
  localparam logic [16:0] BEAM_LIMIT = 17'(MAX_BEAMS);

  // Configuration registers.
  logic [23:0]        win_min;
  logic [23:0]        win_max;
  logic signed [31:0] angle_start;
  logic signed [31:0] angle_step;
  logic [35:0]        rot_row_x;
  logic [35:0]        rot_row_y;
  logic signed [31:0] offset_x;
  logic signed [31:0] offset_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_min     <= 24'd0;
      win_max     <= 24'hFFFFFF;
      angle_start <= 32'sd0;
      angle_step  <= 32'sd0;
      rot_row_x   <= 36'd65536;
      rot_row_y   <= 36'd4294967296;
      offset_x    <= 32'sd0;
      offset_y    <= 32'sd0;
    end else if (cfg_we) begin
      unique case (lstp_pkg::cfg_reg_t'(cfg_index))
        lstp_pkg::REG_RANGE_MIN:   win_min     <= cfg_data[23:0];
        lstp_pkg::REG_RANGE_MAX:   win_max     <= cfg_data[23:0];
        lstp_pkg::REG_ANGLE_START: angle_start <= cfg_data[31:0];
        lstp_pkg::REG_ANGLE_STEP:  angle_step  <= cfg_data[31:0];
        lstp_pkg::REG_ROT_ROW_X:   rot_row_x   <= cfg_data;
        lstp_pkg::REG_ROT_ROW_Y:   rot_row_y   <= cfg_data;
        lstp_pkg::REG_OFFSET_X:    offset_x    <= cfg_data[31:0];
        lstp_pkg::REG_OFFSET_Y:    offset_y    <= cfg_data[31:0];
      endcase
    end
  end

  // The whole pipeline moves when the output register is free or being taken.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Beams outside the scan or the range window enter as bubbles.
  logic beam_ok;
  assign beam_ok = ({5'd0, beam_index} < BEAM_LIMIT) &&
                   (beam_range >= win_min) && (beam_range <= win_max);

  // Stage 1: input register.
  logic        v1;
  logic [11:0] idx1;
  logic [23:0] r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid && beam_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx1 <= beam_index;
      r1   <= beam_range;
    end
  end

  // Stage 2: exact beam angle, start plus index times step.
  logic               v2;
  logic signed [44:0] ang2;
  logic [23:0]        r2;
  logic signed [44:0] idx_w, step_w, start_w, ang_next;

  always_comb begin
    idx_w    = $signed({33'd0, idx1});
    step_w   = 45'(angle_step);
    start_w  = 45'(angle_start);
    ang_next = start_w + idx_w * step_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ang2 <= ang_next;
      r2   <= r1;
    end
  end

  // Stage 3: magnitude and sign, so the reduction works on a positive value.
  logic        v3;
  logic        sg3;
  logic [43:0] mag3;
  logic [23:0] r3;
  logic [44:0] ang_neg;

  assign ang_neg = 45'(-ang2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sg3  <= ang2[44];
      mag3 <= ang2[44] ? ang_neg[43:0] : ang2[43:0];
      r3   <= r2;
    end
  end

  // Reduction stages: one restoring subtraction of a shifted 2*pi per stage.
  logic        rv [0:RN];
  logic        rs [0:RN];
  logic [43:0] rm [0:RN];
  logic [23:0] rr [0:RN];

  assign rv[0] = v3;
  assign rs[0] = sg3;
  assign rm[0] = mag3;
  assign rr[0] = r3;

  for (genvar k = 0; k < RN; k++) begin : g_red
    localparam logic [44:0] SUBV = lstp_pkg::ANG_TWO_PI << (RN - 1 - k);
    logic [44:0] diff;

    assign diff = {1'b0, rm[k]} - SUBV;

    always_ff @(posedge clk) begin
      if (rst) begin
        rv[k+1] <= 1'b0;
      end else if (adv) begin
        rv[k+1] <= rv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rm[k+1] <= ({1'b0, rm[k]} >= SUBV) ? diff[43:0] : rm[k];
        rs[k+1] <= rs[k];
        rr[k+1] <= rr[k];
      end
    end
  end

  // Remainder takes the sign of the angle again.
  logic               vf1;
  logic signed [31:0] f1;
  logic [23:0]        rf1;
  logic signed [31:0] rem_pos;

  assign rem_pos = $signed({1'b0, rm[RN][30:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      vf1 <= 1'b0;
    end else if (adv) begin
      vf1 <= rv[RN];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1  <= rs[RN] ? -rem_pos : rem_pos;
      rf1 <= rr[RN];
    end
  end

  // Fold into the range from -pi to pi.
  localparam logic signed [31:0] TWO_PI_S = $signed(lstp_pkg::ANG_TWO_PI[31:0]);

  logic               vf2;
  logic signed [31:0] f2;
  logic [23:0]        rf2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf2 <= 1'b0;
    end else if (adv) begin
      vf2 <= vf1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      priority if (f1 > lstp_pkg::ANG_PI) begin
        f2 <= f1 - TWO_PI_S;
      end else if (f1 < -lstp_pkg::ANG_PI) begin
        f2 <= f1 + TWO_PI_S;
      end else begin
        f2 <= f1;
      end
      rf2 <= rf1;
    end
  end

  // Fold into the right half plane; a folded result is negated at the end.
  logic               cv [0:CN];
  logic               cn [0:CN];
  logic signed [32:0] cx [0:CN];
  logic signed [32:0] cy [0:CN];
  logic signed [31:0] cz [0:CN];
  logic [23:0]        cr [0:CN];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (adv) begin
      cv[0] <= vf2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      priority if (f2 > lstp_pkg::ANG_HALF_PI) begin
        cz[0] <= f2 - lstp_pkg::ANG_PI;
        cn[0] <= 1'b1;
      end else if (f2 < -lstp_pkg::ANG_HALF_PI) begin
        cz[0] <= f2 + lstp_pkg::ANG_PI;
        cn[0] <= 1'b1;
      end else begin
        cz[0] <= f2;
        cn[0] <= 1'b0;
      end
      cx[0] <= lstp_pkg::CORDIC_GAIN;
      cy[0] <= 33'sd0;
      cr[0] <= rf2;
    end
  end

  // CORDIC in rotation mode, one iteration per stage.
  for (genvar i = 0; i < CN; i++) begin : g_cordic
    localparam logic signed [31:0] ATAN = lstp_pkg::atan_entry(i);
    logic signed [32:0] dx, dy;

    assign dx = cy[i] >>> i;
    assign dy = cx[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else if (adv) begin
        cv[i+1] <= cv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (cz[i] >= 32'sd0) begin
          cx[i+1] <= cx[i] - dx;
          cy[i+1] <= cy[i] + dy;
          cz[i+1] <= cz[i] - ATAN;
        end else begin
          cx[i+1] <= cx[i] + dx;
          cy[i+1] <= cy[i] - dy;
          cz[i+1] <= cz[i] + ATAN;
        end
        cn[i+1] <= cn[i];
        cr[i+1] <= cr[i];
      end
    end
  end

  // Cosine and sine in Q.30 with the half-plane fold undone.
  logic               vc;
  logic signed [32:0] cos_q;
  logic signed [32:0] sin_q;
  logic [23:0]        rc;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (adv) begin
      vc <= cv[CN];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cos_q <= cn[CN] ? -cx[CN] : cx[CN];
      sin_q <= cn[CN] ? -cy[CN] : cy[CN];
      rc    <= cr[CN];
    end
  end

  // Polar to Cartesian: r times cosine and sine, rounded to Q.30 meters.
  logic               vp;
  logic signed [41:0] px;
  logic signed [41:0] py;
  logic signed [57:0] r_s, prod_c, prod_s, rnd_c, rnd_s;

  always_comb begin
    r_s    = $signed({34'd0, rc});
    prod_c = r_s * 58'(cos_q);
    prod_s = r_s * 58'(sin_q);
    rnd_c  = prod_c + 58'sd32768;
    rnd_s  = prod_s + 58'sd32768;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (adv) begin
      vp <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px <= rnd_c[57:16];
      py <= rnd_s[57:16];
    end
  end

  // Rotation products, one multiplier per matrix entry.
  logic               vm;
  logic signed [63:0] mxx, mxy, myx, myy;
  logic signed [63:0] px_w, py_w;

  assign px_w = 64'(px);
  assign py_w = 64'(py);

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (adv) begin
      vm <= vp;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mxx <= 64'($signed(rot_row_x[17:0])) * px_w;
      mxy <= 64'($signed(rot_row_x[35:18])) * py_w;
      myx <= 64'($signed(rot_row_y[17:0])) * px_w;
      myy <= 64'($signed(rot_row_y[35:18])) * py_w;
    end
  end

  // Row sums with the offsets moved to Q.46.
  logic               vs;
  logic signed [63:0] acc_x, acc_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= 1'b0;
    end else if (adv) begin
      vs <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_x <= mxx + mxy + (64'(offset_x) <<< 30);
      acc_y <= myx + myy + (64'(offset_y) <<< 30);
    end
  end

  // Round to Q16.16 and saturate into the output register.
  logic signed [63:0] rnd_x, rnd_y;
  logic signed [33:0] tx, ty;
  logic signed [31:0] sat_x, sat_y;

  always_comb begin
    rnd_x = acc_x + 64'sd536870912;
    rnd_y = acc_y + 64'sd536870912;
    tx    = rnd_x[63:30];
    ty    = rnd_y[63:30];
    priority if (tx > 34'sd2147483647) begin
      sat_x = 32'sh7FFFFFFF;
    end else if (tx < -34'sd2147483648) begin
      sat_x = 32'sh80000000;
    end else begin
      sat_x = tx[31:0];
    end
    priority if (ty > 34'sd2147483647) begin
      sat_y = 32'sh7FFFFFFF;
    end else if (ty < -34'sd2147483648) begin
      sat_y = 32'sh80000000;
    end else begin
      sat_y = ty[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      point_x <= sat_x;
      point_y <= sat_y;
    end
  end

  // The reduction leaves a remainder below 2*pi.
  a_red_bound: assert property (@(posedge clk) disable iff (rst)
    rv[RN] |-> ({1'b0, rm[RN]} < lstp_pkg::ANG_TWO_PI))
    else $error("angle reduction left a remainder of 2*pi or more");

  // The CORDIC starts inside its convergence range.
  a_fold_bound: assert property (@(posedge clk) disable iff (rst)
    cv[0] |-> (cz[0] <= lstp_pkg::ANG_HALF_PI) && (cz[0] >= -lstp_pkg::ANG_HALF_PI))
    else $error("folded angle outside the CORDIC range");

  // After the last iteration the residual angle is close to zero.
  a_cordic_conv: assert property (@(posedge clk) disable iff (rst)
    cv[CN] |-> (cz[CN] <= 32'sd64) && (cz[CN] >= -32'sd64))
    else $error("CORDIC did not converge");

endmodule
